// File: sv/ikcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikcf_pkg
// Types, constants and helpers shared by the follow-the-leader chain solver.
// ----------------------------------------------------------------------------
package ikcf_pkg;

  // field widths
  localparam int COORD_W = 24;
  localparam int ANGLE_W = 16;
  localparam int LEN_W   = 16;
  localparam int CNT_W   = 5;
  localparam int TIME_W  = 16;

  // internal widths
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SUM_W   = COORD_W + 3;
  localparam int OFS_W   = 20;
  localparam int OFS_SH  = 30;
  localparam int MULO_W  = LEN_W + 33 + 1;
  localparam int TRIG_W  = 33;
  localparam int PROD_W  = DIFF_W + TIME_W + 1;
  localparam int MAG_W   = 40;
  localparam int DCNT_W  = 6;

  // CORDIC
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W = 5;
  localparam int CXY_W  = 44;
  localparam int CZ_W   = 34;
  localparam int VEC_SH = 16;
  localparam logic signed [CXY_W-1:0] CORDIC_GAIN = 44'sd652032874;
  localparam logic signed [MULO_W-1:0] OFS_RND = 50'sd536870912;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // target modes
  localparam logic [1:0] MODE_KEEP  = 2'd0;
  localparam logic [1:0] MODE_JUMP  = 2'd1;
  localparam logic [1:0] MODE_GLIDE = 2'd2;

  // register index (paddr bit 2)
  localparam logic REG_SEG_LEN = 1'b0;
  localparam logic REG_SEG_CNT = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [ANGLE_W-1:0]        angle_t;
  typedef logic [3:0]                seg_idx_t;

  typedef struct packed {
    logic [1:0]        target_mode;
    coord_t            new_target_x;
    coord_t            new_target_y;
    logic [TIME_W-1:0] glide_time;
    coord_t            origin_x;
    coord_t            origin_y;
    logic [TIME_W-1:0] frame_dt;
  } in_pl_t;

  typedef struct packed {
    seg_idx_t segment_index;
    coord_t   joint_start_x;
    coord_t   joint_start_y;
    coord_t   joint_end_x;
    coord_t   joint_end_y;
    angle_t   joint_angle;
    logic     last_of_frame;
  } out_pl_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    angle_t hd;
  } seg_rec_t;

  typedef struct packed {
    logic start;
    logic vec;
  } cordic_cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_GOAL, S_GMUL, S_GDIV, S_GWAIT, S_SEGRD, S_AIM, S_VECW, S_ROTST,
    S_ROTW, S_OFSX, S_OFSY, S_ENDC, S_STC, S_SHIFT, S_ORD, S_OCALC, S_OWAIT
  } ikcf_state_e;

  // clamp a widened sum to the signed coordinate range
  function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
    coord_t r;
    if ((&v[SUM_W-1:COORD_W-1]) || !(|v[SUM_W-1:COORD_W-1])) begin
      r = v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: sv/ik_chain_follow_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ik_chain_follow_solver
// Planar follow-the-leader IK chain: one frame in, one record per segment out.
// Per frame: a goal update, two divisions on the serial divider while a glide
//   runs, a vectoring and a rotation pass of the shared 24-step CORDIC per
//   segment (no vectoring pass on a zero aim), then the shift and the records.
// Throughput: one frame per full solve; no new frame until the last record goes.
// Reset: synchronous, rst_n low; chain state reads as zero, registers default.
// ----------------------------------------------------------------------------
module ik_chain_follow_solver #(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ikcf_pkg::in_pl_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ikcf_pkg::out_pl_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import ikcf_pkg::*;

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [6:0] MAX_CNT = 7'(MAX_SEGMENTS);

  ikcf_state_e state_r, state_nxt;

  // configuration
  logic [LEN_W-1:0] len_r;
  logic [CNT_W-1:0] cnt_r;

  // frame and goal state
  in_pl_t            in_r, in_nxt;
  coord_t            goal_x_r, goal_x_nxt, goal_y_r, goal_y_nxt;
  coord_t            from_x_r, from_x_nxt, from_y_r, from_y_nxt;
  coord_t            to_x_r, to_x_nxt, to_y_r, to_y_nxt;
  logic [TIME_W-1:0] left_r, left_nxt, total_r, total_nxt, left_eff;
  logic [IDX_W-1:0]  last_r, last_nxt, seg_i_r, seg_i_nxt;
  logic              axis_r, axis_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;

  // segment datapath
  coord_t            tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  coord_t            end_x_r, end_x_nxt, end_y_r, end_y_nxt;
  angle_t            heading_r, heading_nxt;
  logic signed [TRIG_W-1:0] cos_r, cos_nxt, sin_r, sin_nxt;
  logic signed [OFS_W-1:0]  ofs_x_r, ofs_x_nxt, ofs_y_r, ofs_y_nxt;
  logic signed [DIFF_W-1:0] mx_r, mx_nxt, my_r, my_nxt;

  // output register
  logic    out_valid_r, out_valid_nxt;
  out_pl_t out_r, out_nxt;

  // segment store
  seg_rec_t          seg_mem [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] seg_vld_r;
  seg_rec_t          rd_r, rd_eff, wr_data;
  logic              rd_vld_r, wr_en;

  // shared units
  cordic_cmd_t       cmd;
  logic              cor_done, div_start, div_done;
  angle_t            cor_heading;
  logic signed [TRIG_W-1:0] cor_cos, cor_sin, trig;
  logic [MAG_W-1:0]  div_q, prod_mag;

  // misc combinational
  logic signed [DIFF_W-1:0] aim_dx, aim_dy, gdiff;
  logic signed [PROD_W-1:0] q_ext, q_sg;
  logic signed [MULO_W-1:0] ofs_prod, ofs_rnd;
  logic [6:0]               cnt_clamp;
  coord_t                   to_sel, goal_new, st_x, st_y;

  ikcf_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .vec_dx    (aim_dx),
    .vec_dy    (aim_dy),
    .rot_angle (heading_r),
    .done      (cor_done),
    .heading   (cor_heading),
    .cos_o     (cor_cos),
    .sin_o     (cor_sin)
  );

  ikcf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_mag),
    .divisor  (total_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SEG_CNT) ? {27'd0, cnt_r} : {16'd0, len_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_W'(1280);
      cnt_r <= CNT_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_SEG_CNT) begin
        cnt_r <= pwdata[CNT_W-1:0];
      end else begin
        len_r <= pwdata[LEN_W-1:0];
      end
    end
  end

  // segment store: registered read, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (wr_en) begin
      seg_mem[seg_i_r] <= wr_data;
    end
    rd_r <= seg_mem[seg_i_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        seg_vld_r[seg_i_r] <= 1'b1;
      end
      rd_vld_r <= seg_vld_r[seg_i_r];
    end
  end

  assign rd_eff = rd_vld_r ? rd_r : '0;

  // shared datapath terms
  always_comb begin
    aim_dx    = DIFF_W'(tgt_x_r) - DIFF_W'(rd_eff.ex);
    aim_dy    = DIFF_W'(tgt_y_r) - DIFF_W'(rd_eff.ey);
    gdiff     = axis_r ? (DIFF_W'(from_y_r) - DIFF_W'(to_y_r))
                       : (DIFF_W'(from_x_r) - DIFF_W'(to_x_r));
    prod_mag  = prod_r[PROD_W-1] ? MAG_W'(-prod_r) : MAG_W'(prod_r);
    q_ext     = $signed({{(PROD_W-MAG_W){1'b0}}, div_q});
    q_sg      = prod_r[PROD_W-1] ? -q_ext : q_ext;
    to_sel    = axis_r ? to_y_r : to_x_r;
    goal_new  = COORD_W'(PROD_W'(to_sel) + q_sg);
    trig      = axis_r ? sin_r : cos_r;
    ofs_prod  = MULO_W'($signed({1'b0, len_r})) * MULO_W'(trig);
    ofs_rnd   = ofs_prod + OFS_RND;
    st_x      = sat_coord(SUM_W'(end_x_r) + SUM_W'(ofs_x_r));
    st_y      = sat_coord(SUM_W'(end_y_r) + SUM_W'(ofs_y_r));
    cnt_clamp = {2'b00, cnt_r};
    if (cnt_clamp == 7'd0) begin
      cnt_clamp = 7'd1;
    end else if (cnt_clamp > MAX_CNT) begin
      cnt_clamp = MAX_CNT;
    end
    left_eff = (in_r.target_mode == MODE_GLIDE) ? in_r.glide_time : left_r;
  end

  // sequencer: next state and datapath loads
  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    goal_x_nxt    = goal_x_r;
    goal_y_nxt    = goal_y_r;
    from_x_nxt    = from_x_r;
    from_y_nxt    = from_y_r;
    to_x_nxt      = to_x_r;
    to_y_nxt      = to_y_r;
    left_nxt      = left_r;
    total_nxt     = total_r;
    last_nxt      = last_r;
    seg_i_nxt     = seg_i_r;
    axis_nxt      = axis_r;
    prod_nxt      = prod_r;
    tgt_x_nxt     = tgt_x_r;
    tgt_y_nxt     = tgt_y_r;
    end_x_nxt     = end_x_r;
    end_y_nxt     = end_y_r;
    heading_nxt   = heading_r;
    cos_nxt       = cos_r;
    sin_nxt       = sin_r;
    ofs_x_nxt     = ofs_x_r;
    ofs_y_nxt     = ofs_y_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_data       = rd_eff;
    cmd.start     = 1'b0;
    cmd.vec       = 1'b0;
    div_start     = 1'b0;
    in_stall      = (state_r != S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = S_GOAL;
        end
      end
      // apply the frame's target mode, then run down the glide timer
      S_GOAL: begin
        last_nxt = IDX_W'(cnt_clamp - 7'd1);
        seg_i_nxt = '0;
        axis_nxt = 1'b0;
        if (in_r.target_mode == MODE_JUMP) begin
          goal_x_nxt = in_r.new_target_x;
          goal_y_nxt = in_r.new_target_y;
        end else if (in_r.target_mode == MODE_GLIDE) begin
          to_x_nxt   = in_r.new_target_x;
          to_y_nxt   = in_r.new_target_y;
          from_x_nxt = goal_x_r;
          from_y_nxt = goal_y_r;
          total_nxt  = in_r.glide_time;
        end
        left_nxt  = left_eff;
        state_nxt = S_SEGRD;
        if (left_eff != '0) begin
          left_nxt = (left_eff > in_r.frame_dt) ? (left_eff - in_r.frame_dt) : '0;
          if (total_nxt == '0) begin
            goal_x_nxt = to_x_nxt;
            goal_y_nxt = to_y_nxt;
          end else begin
            state_nxt = S_GMUL;
          end
        end
      end
      S_GMUL: begin
        prod_nxt  = PROD_W'(gdiff) * PROD_W'($signed({1'b0, left_r}));
        state_nxt = S_GDIV;
      end
      S_GDIV: begin
        div_start = 1'b1;
        state_nxt = S_GWAIT;
      end
      S_GWAIT: begin
        if (div_done) begin
          if (axis_r) begin
            goal_y_nxt = goal_new;
            axis_nxt   = 1'b0;
            state_nxt  = S_SEGRD;
          end else begin
            goal_x_nxt = goal_new;
            axis_nxt   = 1'b1;
            state_nxt  = S_GMUL;
          end
        end
      end
      // follow pass, one segment at a time
      S_SEGRD: begin
        if (seg_i_r == '0) begin
          tgt_x_nxt = goal_x_r;
          tgt_y_nxt = goal_y_r;
        end
        state_nxt = S_AIM;
      end
      S_AIM: begin
        if (aim_dx == '0 && aim_dy == '0) begin
          heading_nxt = '0;
          state_nxt   = S_ROTST;
        end else begin
          cmd.start = 1'b1;
          cmd.vec   = 1'b1;
          state_nxt = S_VECW;
        end
      end
      S_VECW: begin
        if (cor_done) begin
          heading_nxt = cor_heading;
          state_nxt   = S_ROTST;
        end
      end
      S_ROTST: begin
        cmd.start = 1'b1;
        state_nxt = S_ROTW;
      end
      S_ROTW: begin
        if (cor_done) begin
          cos_nxt   = cor_cos;
          sin_nxt   = cor_sin;
          axis_nxt  = 1'b0;
          state_nxt = S_OFSX;
        end
      end
      S_OFSX: begin
        ofs_x_nxt = ofs_rnd[OFS_W+OFS_SH-1:OFS_SH];
        axis_nxt  = 1'b1;
        state_nxt = S_OFSY;
      end
      S_OFSY: begin
        ofs_y_nxt = ofs_rnd[OFS_W+OFS_SH-1:OFS_SH];
        axis_nxt  = 1'b0;
        state_nxt = S_ENDC;
      end
      S_ENDC: begin
        end_x_nxt = sat_coord(SUM_W'(tgt_x_r) - SUM_W'(ofs_x_r));
        end_y_nxt = sat_coord(SUM_W'(tgt_y_r) - SUM_W'(ofs_y_r));
        state_nxt = S_STC;
      end
      S_STC: begin
        wr_en      = 1'b1;
        wr_data.sx = st_x;
        wr_data.sy = st_y;
        wr_data.ex = end_x_r;
        wr_data.ey = end_y_r;
        wr_data.hd = heading_r;
        tgt_x_nxt  = end_x_r;
        tgt_y_nxt  = end_y_r;
        if (seg_i_r == last_r) begin
          state_nxt = S_SHIFT;
        end else begin
          seg_i_nxt = seg_i_r + 1'b1;
          state_nxt = S_SEGRD;
        end
      end
      // translate so the last end lands on the anchor
      S_SHIFT: begin
        mx_nxt    = DIFF_W'(in_r.origin_x) - DIFF_W'(end_x_r);
        my_nxt    = DIFF_W'(in_r.origin_y) - DIFF_W'(end_y_r);
        seg_i_nxt = '0;
        state_nxt = S_ORD;
      end
      S_ORD: begin
        state_nxt = S_OCALC;
      end
      S_OCALC: begin
        wr_en      = 1'b1;
        wr_data.sx = sat_coord(SUM_W'(rd_eff.sx) + SUM_W'(mx_r));
        wr_data.sy = sat_coord(SUM_W'(rd_eff.sy) + SUM_W'(my_r));
        wr_data.ex = sat_coord(SUM_W'(rd_eff.ex) + SUM_W'(mx_r));
        wr_data.ey = sat_coord(SUM_W'(rd_eff.ey) + SUM_W'(my_r));
        wr_data.hd = rd_eff.hd;
        out_nxt.segment_index = seg_idx_t'(seg_i_r);
        out_nxt.joint_start_x = wr_data.sx;
        out_nxt.joint_start_y = wr_data.sy;
        out_nxt.joint_end_x   = wr_data.ex;
        out_nxt.joint_end_y   = wr_data.ey;
        out_nxt.joint_angle   = wr_data.hd;
        out_nxt.last_of_frame = (seg_i_r == last_r);
        out_valid_nxt = 1'b1;
        state_nxt     = S_OWAIT;
      end
      S_OWAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (seg_i_r == last_r) begin
            state_nxt = S_IDLE;
          end else begin
            seg_i_nxt = seg_i_r + 1'b1;
            state_nxt = S_ORD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      goal_x_r    <= '0;
      goal_y_r    <= '0;
      from_x_r    <= '0;
      from_y_r    <= '0;
      to_x_r      <= '0;
      to_y_r      <= '0;
      left_r      <= '0;
      total_r     <= '0;
      seg_i_r     <= '0;
      last_r      <= '0;
      axis_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      goal_x_r    <= goal_x_nxt;
      goal_y_r    <= goal_y_nxt;
      from_x_r    <= from_x_nxt;
      from_y_r    <= from_y_nxt;
      to_x_r      <= to_x_nxt;
      to_y_r      <= to_y_nxt;
      left_r      <= left_nxt;
      total_r     <= total_nxt;
      seg_i_r     <= seg_i_nxt;
      last_r      <= last_nxt;
      axis_r      <= axis_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    in_r      <= in_nxt;
    prod_r    <= prod_nxt;
    tgt_x_r   <= tgt_x_nxt;
    tgt_y_r   <= tgt_y_nxt;
    end_x_r   <= end_x_nxt;
    end_y_r   <= end_y_nxt;
    heading_r <= heading_nxt;
    cos_r     <= cos_nxt;
    sin_r     <= sin_nxt;
    ofs_x_r   <= ofs_x_nxt;
    ofs_y_r   <= ofs_y_nxt;
    mx_r      <= mx_nxt;
    my_r      <= my_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: sv/ikcf_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikcf_cordic
// Shared iterative CORDIC: vectoring mode gives the heading of (dx, dy),
// rotation mode gives cos and sin of a heading. One micro-rotation a cycle.
// ----------------------------------------------------------------------------
module ikcf_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ikcf_pkg::cordic_cmd_t               cmd,
  input  logic signed [ikcf_pkg::DIFF_W-1:0]  vec_dx,
  input  logic signed [ikcf_pkg::DIFF_W-1:0]  vec_dy,
  input  ikcf_pkg::angle_t                    rot_angle,
  output logic                                done,
  output ikcf_pkg::angle_t                    heading,
  output logic signed [ikcf_pkg::TRIG_W-1:0]  cos_o,
  output logic signed [ikcf_pkg::TRIG_W-1:0]  sin_o
);
  import ikcf_pkg::*;

  logic signed [CXY_W-1:0] x_r, x_nxt, y_r, y_nxt, xs, ys, x_ld, y_ld;
  logic signed [CZ_W-1:0]  z_r, z_nxt, z_ld, atan_s;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic                    busy_r, busy_nxt, vec_r, vec_nxt, neg_r, neg_nxt;
  logic                    done_r, done_nxt;
  logic [31:0]             rot_a, rot_q, rot_fold, z_round;
  logic                    rot_neg, dir_pos;

  // start values
  always_comb begin
    rot_a    = {rot_angle, {(32-ANGLE_W){1'b0}}};
    rot_q    = rot_a + 32'h4000_0000;
    rot_neg  = rot_q[31];
    rot_fold = rot_neg ? (rot_a + 32'h8000_0000) : rot_a;
    if (cmd.vec) begin
      x_ld = CXY_W'(vec_dx) <<< VEC_SH;
      y_ld = CXY_W'(vec_dy) <<< VEC_SH;
      z_ld = '0;
      if (vec_dx < 0) begin
        x_ld = -x_ld;
        y_ld = -y_ld;
        z_ld = CZ_W'(33'h0_8000_0000);
      end
    end else begin
      x_ld = CORDIC_GAIN;
      y_ld = '0;
      z_ld = CZ_W'($signed(rot_fold));
    end
  end

  // one micro-rotation
  always_comb begin
    xs       = x_r >>> step_r;
    ys       = y_r >>> step_r;
    atan_s   = CZ_W'(ATAN_TURNS[step_r]);
    dir_pos  = vec_r ? !(y_r > 0) : (z_r >= 0);
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    vec_nxt  = vec_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      x_nxt    = x_ld;
      y_nxt    = y_ld;
      z_nxt    = z_ld;
      step_nxt = '0;
      busy_nxt = 1'b1;
      vec_nxt  = cmd.vec;
      neg_nxt  = !cmd.vec && rot_neg;
    end else if (busy_r) begin
      if (dir_pos) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - atan_s;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + atan_s;
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    vec_r <= vec_nxt;
    neg_r <= neg_nxt;
  end

  // results
  always_comb begin
    z_round = z_r[31:0] + (32'd1 << (31 - ANGLE_W));
    heading = z_round[31:32-ANGLE_W];
    cos_o   = neg_r ? -TRIG_W'(x_r) : TRIG_W'(x_r);
    sin_o   = neg_r ? -TRIG_W'(y_r) : TRIG_W'(y_r);
  end

  assign done = done_r;

endmodule

// File: sv/ikcf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikcf_div
// Restoring unsigned divider, one quotient bit a cycle, for glide blending.
// ----------------------------------------------------------------------------
module ikcf_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [ikcf_pkg::MAG_W-1:0]        dividend,
  input  logic [ikcf_pkg::TIME_W-1:0]       divisor,
  output logic                              done,
  output logic [ikcf_pkg::MAG_W-1:0]        quotient
);
  import ikcf_pkg::*;

  logic [MAG_W-1:0]  quo_r, quo_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt, dsr_r, dsr_nxt;
  logic [TIME_W:0]   trial;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    trial    = {rem_r, quo_r[MAG_W-1]};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = DCNT_W'(MAG_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // trial subtract
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = TIME_W'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[TIME_W-1:0];
        quo_nxt = {quo_r[MAG_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: sv/ikcf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikcf_checker
// Port-level checks on the chain solver's transaction ordering.
// ----------------------------------------------------------------------------
module ikcf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input ikcf_pkg::out_pl_t out_data
);
  import ikcf_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no new frame while a result is pending
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while a result is pending");

  // a new frame starts with the output side empty and locks the input
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !out_valid ##1 in_stall && !out_valid)
    else $error("frame start overlaps results");

  // more records follow until the last one
  a_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_of_frame |=> in_stall)
    else $error("input reopened before the last record");

endmodule

bind ik_chain_follow_solver ikcf_checker u_ikcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: sim/ik_chain_follow_solver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ik_chain_follow_solver_tb
// Self-checking bench for the follow-the-leader chain solver. Frames are sent
// through the valid/stall input channel, and a bit-exact model of the goal
// glide, CORDIC aim and chain shift predicts every segment record. Checks run
// over several length and count settings, with random sender gaps, receiver
// stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module ik_chain_follow_solver_tb;
  import ikcf_pkg::*;

  localparam int     N_SEG       = 16;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam logic [2:0] ADDR_SEG_LEN = 3'd0;
  localparam logic [2:0] ADDR_SEG_CNT = 3'd4;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  // chain model and record scoreboard
  class chain_scoreboard;
    longint  start_x[N_SEG], start_y[N_SEG], end_x[N_SEG], end_y[N_SEG];
    angle_t  heading[N_SEG];
    longint  goal_x, goal_y, from_x, from_y, to_x, to_y;
    int      glide_left, glide_total;
    int      seg_len, seg_cnt;
    int      errors;
    out_pl_t records_due[$];

    function void clear_state();
      for (int i = 0; i < N_SEG; i++) begin
        start_x[i] = 0; start_y[i] = 0; end_x[i] = 0; end_y[i] = 0;
        heading[i] = '0;
      end
      goal_x = 0; goal_y = 0; from_x = 0; from_y = 0; to_x = 0; to_y = 0;
      glide_left = 0; glide_total = 0;
      seg_len = 1280; seg_cnt = 1; errors = 0;
    endfunction

    function void set_length(logic [31:0] v);
      seg_len = int'(v[15:0]);
    endfunction

    function void set_count(logic [31:0] v);
      seg_cnt = int'(v[4:0]);
    endfunction

    function longint clamp(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    // vectoring CORDIC, heading as a binary angle
    function angle_t aim_angle(longint dx, longint dy);
      longint x, y, xs, ys;
      logic [31:0] z;
      if (dx == 0 && dy == 0) return '0;
      x = dx * 65536;
      y = dy * 65536;
      z = '0;
      if (x < 0) begin
        x = -x; y = -y; z = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys; y = y - xs; z = z + ATAN_TURNS[i];
        end else begin
          x = x - ys; y = y + xs; z = z - ATAN_TURNS[i];
        end
      end
      z = z + 32'h0000_8000;
      return z[31:16];
    endfunction

    // rotation CORDIC, Q1.30 cos and sin, folded into the right half-plane
    function void unit_vector(angle_t h, output longint c, output longint s);
      logic [31:0] a, t;
      longint x, y, z, xs, ys;
      bit neg;
      a = {h, 16'h0000};
      t = a + 32'h4000_0000;
      neg = t[31];
      if (neg) a = a + 32'h8000_0000;
      z = longint'($signed(a));
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - longint'(ATAN_TURNS[i]);
        end else begin
          x = x + ys; y = y - xs; z = z + longint'(ATAN_TURNS[i]);
        end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
    endfunction

    function void chase(int i, longint tx, longint ty);
      longint c, s, ox, oy;
      angle_t h;
      h = aim_angle(tx - end_x[i], ty - end_y[i]);
      unit_vector(h, c, s);
      ox = (longint'(seg_len) * c + 64'sd536870912) >>> 30;
      oy = (longint'(seg_len) * s + 64'sd536870912) >>> 30;
      heading[i] = h;
      end_x[i]   = clamp(tx - ox);
      end_y[i]   = clamp(ty - oy);
      start_x[i] = clamp(end_x[i] + ox);
      start_y[i] = clamp(end_y[i] + oy);
    endfunction

    // accepted frame: update goal, solve chain, queue its records
    function void note_frame(in_pl_t f);
      int n;
      longint mx, my;
      out_pl_t r;
      n = seg_cnt < 1 ? 1 : (seg_cnt > N_SEG ? N_SEG : seg_cnt);
      if (f.target_mode == MODE_JUMP) begin
        goal_x = longint'(f.new_target_x);
        goal_y = longint'(f.new_target_y);
      end else if (f.target_mode == MODE_GLIDE) begin
        to_x = longint'(f.new_target_x);
        to_y = longint'(f.new_target_y);
        from_x = goal_x;
        from_y = goal_y;
        glide_left  = int'(f.glide_time);
        glide_total = int'(f.glide_time);
      end
      if (glide_left > 0) begin
        glide_left = glide_left > int'(f.frame_dt) ? glide_left - int'(f.frame_dt) : 0;
        if (glide_total == 0) begin
          goal_x = to_x; goal_y = to_y;
        end else begin
          goal_x = to_x + (from_x - to_x) * glide_left / glide_total;
          goal_y = to_y + (from_y - to_y) * glide_left / glide_total;
        end
      end
      chase(0, goal_x, goal_y);
      for (int i = 1; i < n; i++) chase(i, end_x[i-1], end_y[i-1]);
      mx = longint'(f.origin_x) - end_x[n-1];
      my = longint'(f.origin_y) - end_y[n-1];
      for (int i = 0; i < n; i++) begin
        start_x[i] = clamp(start_x[i] + mx);
        start_y[i] = clamp(start_y[i] + my);
        end_x[i]   = clamp(end_x[i] + mx);
        end_y[i]   = clamp(end_y[i] + my);
        r.segment_index = seg_idx_t'(i);
        r.joint_start_x = coord_t'(start_x[i]);
        r.joint_start_y = coord_t'(start_y[i]);
        r.joint_end_x   = coord_t'(end_x[i]);
        r.joint_end_y   = coord_t'(end_y[i]);
        r.joint_angle   = heading[i];
        r.last_of_frame = (i == n - 1);
        records_due.insert(records_due.size(), r);
      end
    endfunction

    function void check_record(out_pl_t got);
      out_pl_t want;
      if (records_due.size() == 0) begin
        $error("unexpected record: segment %0d", got.segment_index);
        errors++;
        return;
      end
      want = records_due.pop_front();
      if (got.segment_index !== want.segment_index) begin
        $error("segment_index: expected %0d, got %0d", want.segment_index, got.segment_index);
        errors++;
      end
      if (got.joint_start_x !== want.joint_start_x) begin
        $error("joint_start_x: expected %0d, got %0d", want.joint_start_x, got.joint_start_x);
        errors++;
      end
      if (got.joint_start_y !== want.joint_start_y) begin
        $error("joint_start_y: expected %0d, got %0d", want.joint_start_y, got.joint_start_y);
        errors++;
      end
      if (got.joint_end_x !== want.joint_end_x) begin
        $error("joint_end_x: expected %0d, got %0d", want.joint_end_x, got.joint_end_x);
        errors++;
      end
      if (got.joint_end_y !== want.joint_end_y) begin
        $error("joint_end_y: expected %0d, got %0d", want.joint_end_y, got.joint_end_y);
        errors++;
      end
      if (got.joint_angle !== want.joint_angle) begin
        $error("joint_angle: expected %0d, got %0d", want.joint_angle, got.joint_angle);
        errors++;
      end
      if (got.last_of_frame !== want.last_of_frame) begin
        $error("last_of_frame: expected %0d, got %0d", want.last_of_frame, got.last_of_frame);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_pl_t      in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_pl_t     out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  chain_scoreboard sb = new();
  int     frames_taken = 0;
  int     burst_left = 0;
  longint cycles = 0;

  ik_chain_follow_solver dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_record(out_data);
  end

  // receiver stall pattern, with one long hold-off mid-run
  initial begin
    int mode, len;
    bit held;
    held = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (!held && frames_taken >= 120) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      len  = $urandom_range(5, 80);
      repeat (len) begin
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_stall <= ($urandom_range(0, 3) != 0);
          end
        endcase
        @(posedge clk);
      end
    end
  end

  // APB register write: setup then access
  task automatic reg_write(logic [2:0] addr, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_SEG_LEN) sb.set_length(val);
    else sb.set_count(val);
  endtask

  // offer one frame; bursts of back-to-back frames with random gaps between
  task automatic send_frame(in_pl_t f);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (in_stall);
    sb.note_frame(f);
    frames_taken++;
  endtask

  function automatic in_pl_t make_frame(logic [1:0] m, int tx, int ty, int gt,
                                        int ox, int oy, int dt);
    in_pl_t f;
    f.target_mode  = m;
    f.new_target_x = coord_t'(tx);
    f.new_target_y = coord_t'(ty);
    f.glide_time   = gt[15:0];
    f.origin_x     = coord_t'(ox);
    f.origin_y     = coord_t'(oy);
    f.frame_dt     = dt[15:0];
    return f;
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(0, 3) == 0) return int'($signed($urandom() << 8)) >>> 8;
    return $urandom_range(0, 131072) - 65536;
  endfunction

  function automatic in_pl_t rand_frame();
    int w;
    logic [1:0] m;
    int gt, dt;
    w = $urandom_range(0, 99);
    m = (w < 40) ? MODE_KEEP : (w < 65) ? MODE_JUMP : (w < 90) ? MODE_GLIDE : MODE_UNUSED;
    gt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4096);
    dt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 512);
    return make_frame(m, rand_coord(), rand_coord(), gt, rand_coord(), rand_coord(), dt);
  endfunction

  // let the chain drain before touching the registers
  task automatic drain();
    while (sb.records_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    int lens[6];
    int cnts[6];
    sb.clear_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames at the reset settings
    send_frame(make_frame(MODE_KEEP, 0, 0, 0, 0, 0, 0));                  // zero aim
    send_frame(make_frame(MODE_JUMP, 8388607, 8388607, 0, 0, 0, 65535));
    send_frame(make_frame(MODE_JUMP, -8388608, -8388608, 0, 8388607, 8388607, 0));
    send_frame(make_frame(MODE_JUMP, 8388607, -8388608, 0, -8388608, -8388608, 1));
    send_frame(make_frame(MODE_JUMP, 1000, 2000, 0, 0, 0, 0));
    send_frame(make_frame(MODE_GLIDE, -3000, 500, 0, 10, 10, 16));         // glide of zero time
    send_frame(make_frame(MODE_GLIDE, 4000, -4000, 1000, 0, 0, 100));
    send_frame(make_frame(MODE_KEEP, 0, 0, 0, 0, 0, 300));
    send_frame(make_frame(MODE_JUMP, 7, 7, 0, 0, 0, 100));                 // jump mid-glide
    send_frame(make_frame(MODE_UNUSED, 0, 0, 65535, 0, 0, 200));           // unused mode
    send_frame(make_frame(MODE_KEEP, 0, 0, 0, -256, 256, 65535));          // timer saturates
    send_frame(make_frame(MODE_GLIDE, -8388608, 8388607, 65535, 0, 0, 65535));
    send_frame(make_frame(MODE_JUMP, 0, 0, 0, 0, 0, 0));
    send_frame(make_frame(MODE_KEEP, 0, 0, 0, 0, 0, 0));
    in_valid <= 1'b0;
    drain();

    // settings per phase, extremes included; counts 0 and 31 exercise the clamp
    lens = '{0, 65535, 1280, 1, 40000, 0};
    cnts = '{0, 16, 31, 3, 7, 2};
    lens[5] = $urandom_range(0, 65535);
    cnts[5] = $urandom_range(1, 16);
    for (int p = 0; p < 6; p++) begin
      reg_write(ADDR_SEG_LEN, lens[p]);
      reg_write(ADDR_SEG_CNT, cnts[p]);
      repeat (48) send_frame(rand_frame());
      in_valid <= 1'b0;
      drain();
    end

    repeat (200) @(posedge clk);
    if (sb.records_due.size() != 0) begin
      $error("%0d records never arrived", sb.records_due.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: ik_chain_follow_solver.f
sv/ikcf_pkg.sv
sv/ikcf_cordic.sv
sv/ikcf_div.sv
sv/ik_chain_follow_solver.sv
sv/ikcf_checker.sv
sim/ik_chain_follow_solver_tb.sv
